>>> hw/rtl/qme_pkg.sv
// Shared types, codes and helpers of the quadrature mouse emulator.
`default_nettype none

package qme_pkg;

  localparam int unsigned CountW      = 16;
  localparam int unsigned DivW        = 8;
  localparam int unsigned SeqW        = 8;
  localparam int unsigned BtnW        = 3;
  localparam int unsigned CfgIndexW   = 3;
  localparam int unsigned CfgDataW    = 8;
  localparam int unsigned RemBitsStep = 4;
  localparam int unsigned RemSteps    = CountW / RemBitsStep;
  localparam int unsigned RemCntW     = $clog2(RemSteps);

  localparam int unsigned CmdDepthDefault = 2;
  localparam int unsigned ResDepthDefault = 2;

  localparam logic [SeqW-1:0] SeqReset = 8'd180;
  localparam logic [DivW-1:0] DivReset = 8'd1;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_TICK    = 2'd1,
    OP_BUTTONS = 2'd2,
    OP_NOP     = 2'd3
  } opcode_e;

  typedef enum logic [CfgIndexW-1:0] {
    REG_QUAD_SEQUENCE = 3'd0,
    REG_SWAP_AXES     = 3'd1,
    REG_INVERT_X      = 3'd2,
    REG_INVERT_Y      = 3'd3,
    REG_STEP_DIVISOR  = 3'd4
  } reg_index_e;

  typedef struct packed {
    logic [1:0]              opcode;
    logic signed [CountW-1:0] delta_x;
    logic signed [CountW-1:0] delta_y;
    logic [BtnW-1:0]         button_bits;
  } in_t;

  typedef struct packed {
    logic xa_drive_low;
    logic xb_drive_low;
    logic ya_drive_low;
    logic yb_drive_low;
    logic left_drive_low;
    logic right_drive_low;
    logic middle_drive_low;
    logic steps_pending;
    logic load_refused;
  } out_t;

  typedef struct packed {
    logic [SeqW-1:0] quad_sequence;
    logic            swap_axes;
    logic            invert_x;
    logic            invert_y;
    logic [DivW-1:0] step_divisor;
  } cfg_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    opcode_e           kind;
    logic [CountW-1:0] x;
    logic [CountW-1:0] y;
    logic [BtnW-1:0]   btn;
  } cmd_t;

  // Line is pulled low when the table level for this phase and line is 0.
  function automatic logic level_low(input logic [SeqW-1:0] seq, input logic [1:0] phase,
                                     input logic line_b);
    logic [2:0] sh;
    sh = {phase, line_b};
    return ~seq[sh];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/quadrature_mouse_emulator.sv
// Top level of the quadrature mouse emulator: register file, front end and back end.
//
// Commands enter through a queue port: an item is taken when push is high and full low.
// Results leave through a queue port: out_o holds the oldest result while empty is low,
// and it is taken when pop is high. Every command yields exactly one result, in order.
// Configuration writes use cfg_valid_i/cfg_ready_o with a register index and data; the
// port is always ready, and writes belong to idle periods only.
// A load, buttons or no-op command is registered in the command queue, and its result is
// then registered in the result queue by the back end. A tick first starts the remainder
// units, which test each magnitude against the step divisor four bits a cycle, and then
// updates the counts and phases; the back end takes no other command until it is done.
// Throughput: one load or buttons command per cycle while the result queue has room.
// The command queue holds CmdDepth items and the result queue ResDepth results; when the
// receiver stops popping, the back end halts with the result queue full, and full rises
// once the command queue fills behind it.
// Reset clears both queues, the counts, phases and buttons, and loads the register
// defaults (phase table 180, divisor 1, no swap, no inversion).
`default_nettype none

module quadrature_mouse_emulator #(
  parameter int unsigned CmdDepth = qme_pkg::CmdDepthDefault,
  parameter int unsigned ResDepth = qme_pkg::ResDepthDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire qme_pkg::in_t                  in_i,
  output logic                               empty,
  input  wire logic                          pop,
  output qme_pkg::out_t                      out_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [qme_pkg::CfgIndexW-1:0] cfg_index_i,
  input  wire logic [qme_pkg::CfgDataW-1:0]  cfg_data_i
);

  qme_pkg::cfg_t cfg_q;
  logic          cmd_valid, cmd_pop;
  qme_pkg::cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.quad_sequence <= qme_pkg::SeqReset;
      cfg_q.swap_axes     <= 1'b0;
      cfg_q.invert_x      <= 1'b0;
      cfg_q.invert_y      <= 1'b0;
      cfg_q.step_divisor  <= qme_pkg::DivReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        qme_pkg::REG_QUAD_SEQUENCE: cfg_q.quad_sequence <= cfg_data_i;
        qme_pkg::REG_SWAP_AXES:     cfg_q.swap_axes     <= cfg_data_i[0];
        qme_pkg::REG_INVERT_X:      cfg_q.invert_x      <= cfg_data_i[0];
        qme_pkg::REG_INVERT_Y:      cfg_q.invert_y      <= cfg_data_i[0];
        qme_pkg::REG_STEP_DIVISOR:  cfg_q.step_divisor  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  qme_front #(
    .Depth (CmdDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .push        (push),
    .full        (full),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  qme_back #(
    .Depth (ResDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

>>> hw/rtl/qme_front.sv
// Command front end: decodes and pre-orients items and queues them for the back end.
`default_nettype none

module qme_front #(
  parameter int unsigned Depth = qme_pkg::CmdDepthDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire qme_pkg::cfg_t cfg_i,
  input  wire logic          push,
  output logic               full,
  input  wire qme_pkg::in_t  in_i,
  output logic               cmd_valid_o,
  output qme_pkg::cmd_t      cmd_o,
  input  wire logic          cmd_pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  qme_pkg::cmd_t       mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;
  qme_pkg::cmd_t       cmd_new;
  logic [qme_pkg::CountW-1:0] x_raw, y_raw;
  logic                wr_en, rd_en;

  always_comb begin
    x_raw = cfg_i.swap_axes ? in_i.delta_y : in_i.delta_x;
    y_raw = cfg_i.swap_axes ? in_i.delta_x : in_i.delta_y;
    cmd_new.kind = qme_pkg::opcode_e'(in_i.opcode);
    cmd_new.x    = cfg_i.invert_x ? qme_pkg::CountW'(16'd0 - x_raw) : x_raw;
    cmd_new.y    = cfg_i.invert_y ? qme_pkg::CountW'(16'd0 - y_raw) : y_raw;
    cmd_new.btn  = in_i.button_bits;
  end

  assign full        = (count_q == CntW'(Depth));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = mem_q[rd_ptr_q];
  assign wr_en       = push && !full;
  assign rd_en       = cmd_pop_i && cmd_valid_o;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count_q <= count_q + 1'b1;
      end else if (rd_en && !wr_en) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/qme_rem.sv
// Iterative remainder unit: tests a 16-bit magnitude for divisibility, four bits a cycle.
`default_nettype none

module qme_rem (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [qme_pkg::CountW-1:0] mag_i,
  input  wire logic [qme_pkg::DivW-1:0]   div_i,
  output logic                            done_o,
  output logic                            zero_o
);

  logic [qme_pkg::CountW-1:0]  num_q;
  logic [qme_pkg::DivW-1:0]    rem_q, rem_d;
  logic [qme_pkg::RemCntW-1:0] cnt_q;
  logic                        busy_q, done_q;

  // Restoring remainder over the top bits of the shifting numerator.
  always_comb begin
    logic [qme_pkg::DivW:0] t;
    rem_d = rem_q;
    for (int i = 0; i < qme_pkg::RemBitsStep; i++) begin
      t = {rem_d, num_q[qme_pkg::CountW-1-i]};
      if (t >= {1'b0, div_i}) begin
        t = t - {1'b0, div_i};
      end
      rem_d = t[qme_pkg::DivW-1:0];
    end
  end

  assign done_o = done_q;
  assign zero_o = (rem_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == qme_pkg::RemCntW'(qme_pkg::RemSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= mag_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= num_q << qme_pkg::RemBitsStep;
      rem_q <= rem_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/qme_back.sv
// Command back end: carries out loads, ticks and button updates and queues the results.
`default_nettype none

module qme_back #(
  parameter int unsigned Depth = qme_pkg::ResDepthDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire qme_pkg::cfg_t cfg_i,
  input  wire logic          cmd_valid_i,
  input  wire qme_pkg::cmd_t cmd_i,
  output logic               cmd_pop_o,
  output logic               empty,
  input  wire logic          pop,
  output qme_pkg::out_t      out_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_e;

  state_e                     state_q, state_d;
  logic [qme_pkg::CountW-1:0] x_rem_q, x_rem_d, y_rem_q, y_rem_d;
  logic [1:0]                 x_ph_q, x_ph_d, y_ph_q, y_ph_d;
  logic [qme_pkg::BtnW-1:0]   btn_q, btn_d;

  qme_pkg::out_t              res_mem_q [Depth];
  logic [PtrW-1:0]            wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]            count_q;
  logic                       res_full, res_push, res_pop, refused;
  qme_pkg::out_t              res_new;

  logic [qme_pkg::DivW-1:0]   div_eff;
  logic [qme_pkg::CountW-1:0] x_mag, y_mag;
  logic                       rem_start, x_done, y_done, x_zero, y_zero;
  logic                       pending;

  assign div_eff = (cfg_i.step_divisor == '0) ? qme_pkg::DivW'(1) : cfg_i.step_divisor;
  assign x_mag   = x_rem_q[qme_pkg::CountW-1] ? qme_pkg::CountW'(16'd0 - x_rem_q) : x_rem_q;
  assign y_mag   = y_rem_q[qme_pkg::CountW-1] ? qme_pkg::CountW'(16'd0 - y_rem_q) : y_rem_q;
  assign pending = (x_rem_q != '0) || (y_rem_q != '0);

  qme_rem u_rem_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rem_start),
    .mag_i   (x_mag),
    .div_i   (div_eff),
    .done_o  (x_done),
    .zero_o  (x_zero)
  );

  qme_rem u_rem_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rem_start),
    .mag_i   (y_mag),
    .div_i   (div_eff),
    .done_o  (y_done),
    .zero_o  (y_zero)
  );

  always_comb begin
    state_d   = state_q;
    x_rem_d   = x_rem_q;
    y_rem_d   = y_rem_q;
    x_ph_d    = x_ph_q;
    y_ph_d    = y_ph_q;
    btn_d     = btn_q;
    cmd_pop_o = 1'b0;
    rem_start = 1'b0;
    res_push  = 1'b0;
    refused   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        // Start only with room for the result, so the back end never drops one.
        if (cmd_valid_i && !res_full) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.kind)
            qme_pkg::OP_LOAD: begin
              res_push = 1'b1;
              if (pending) begin
                refused = 1'b1;
              end else begin
                x_rem_d = cmd_i.x;
                y_rem_d = cmd_i.y;
              end
            end
            qme_pkg::OP_TICK: begin
              rem_start = 1'b1;
              state_d   = ST_DIV;
            end
            qme_pkg::OP_BUTTONS: begin
              res_push = 1'b1;
              btn_d    = cmd_i.btn;
            end
            default: begin
              res_push = 1'b1;
            end
          endcase
        end
      end
      ST_DIV: begin
        if (x_done && y_done) begin
          res_push = 1'b1;
          state_d  = ST_IDLE;
          if (x_rem_q != '0) begin
            if (x_zero) begin
              x_ph_d = x_rem_q[qme_pkg::CountW-1] ? x_ph_q - 1'b1 : x_ph_q + 1'b1;
            end
            x_rem_d = x_rem_q[qme_pkg::CountW-1] ? x_rem_q + 1'b1 : x_rem_q - 1'b1;
          end
          if (y_rem_q != '0) begin
            if (y_zero) begin
              y_ph_d = y_rem_q[qme_pkg::CountW-1] ? y_ph_q - 1'b1 : y_ph_q + 1'b1;
            end
            y_rem_d = y_rem_q[qme_pkg::CountW-1] ? y_rem_q + 1'b1 : y_rem_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result reflects the state after the update.
  always_comb begin
    res_new.xa_drive_low     = qme_pkg::level_low(cfg_i.quad_sequence, x_ph_d, 1'b0);
    res_new.xb_drive_low     = qme_pkg::level_low(cfg_i.quad_sequence, x_ph_d, 1'b1);
    res_new.ya_drive_low     = qme_pkg::level_low(cfg_i.quad_sequence, y_ph_d, 1'b0);
    res_new.yb_drive_low     = qme_pkg::level_low(cfg_i.quad_sequence, y_ph_d, 1'b1);
    res_new.left_drive_low   = btn_d[0];
    res_new.right_drive_low  = btn_d[1];
    res_new.middle_drive_low = btn_d[2];
    res_new.steps_pending    = (x_rem_d != '0) || (y_rem_d != '0);
    res_new.load_refused     = refused;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      x_rem_q <= '0;
      y_rem_q <= '0;
      x_ph_q  <= '0;
      y_ph_q  <= '0;
      btn_q   <= '0;
    end else begin
      state_q <= state_d;
      x_rem_q <= x_rem_d;
      y_rem_q <= y_rem_d;
      x_ph_q  <= x_ph_d;
      y_ph_q  <= y_ph_d;
      btn_q   <= btn_d;
    end
  end

  assign res_full = (count_q == CntW'(Depth));
  assign empty    = (count_q == '0);
  assign out_o    = res_mem_q[rd_ptr_q];
  assign res_pop  = pop && !empty;

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_mem_q[wr_ptr_q] <= res_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (res_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (res_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (res_push && !res_pop) begin
        count_q <= count_q + 1'b1;
      end else if (res_pop && !res_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/qme_checker.sv
// Port-level checks of the quadrature mouse emulator, bound to the top level.
`default_nettype none

module qme_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          push,
  input wire logic          full,
  input wire logic          empty,
  input wire logic          pop,
  input wire qme_pkg::out_t out_o
);

  // A waiting result stays put until it is popped.
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_o)))
    else $error("waiting result changed or vanished without a pop");

  // A load is refused only while steps are pending, and the refusal leaves them pending.
  a_refused_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_o.load_refused) |-> out_o.steps_pending)
    else $error("refused load reported with no steps pending");

  // Both queues come out of reset drained.
  a_reset_drained: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> (empty && !full))
    else $error("queues not drained after reset");

  // The command queue fills only through a transfer.
  a_full_needs_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!full && !push) |=> !full)
    else $error("full rose without a command transfer");

endmodule

bind quadrature_mouse_emulator qme_checker u_qme_checker (.*);

`default_nettype wire
